>>> hdl/cwmv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwmv_pkg
// Shared types, constants and single-precision arithmetic steps of the
// compressed-weight matrix-vector unit.
// ----------------------------------------------------------------------------
package cwmv_pkg;

   localparam int MaxRowLength  = 4096;
   localparam int AddrWidth     = $clog2(MaxRowLength);
   localparam int LenWidth      = 13;
   localparam int RowsWidth     = 16;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;
   localparam int FifoDepth     = 4;
   localparam int FifoPtrWidth  = $clog2(FifoDepth);

   localparam logic [31:0] QuietBit   = 32'h0040_0000;
   localparam logic [31:0] DefaultNan = 32'hFFC0_0000;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_WEIGHT_FORMAT = 2'd0,
      CSR_BIAS_ENABLE   = 2'd1,
      CSR_ROW_LENGTH    = 2'd2,
      CSR_ROWS_IN_USE   = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_ACTIVATION = 1'b0,
      KIND_WEIGHT     = 1'b1
   } kind_type;

   typedef enum logic {
      FMT_BF16 = 1'b0,
      FMT_INT8 = 1'b1
   } format_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL1,
      B_MUL2,
      B_MUL3,
      B_ADD1,
      B_ADD2,
      B_FIN
   } back_state_type;

   // One classified weight item, ready for the arithmetic back end.
   typedef struct packed {
      logic [31:0] weight;
      logic [31:0] act;
      logic        first;
      logic [31:0] start;
      logic        last;
      logic        scale;
      logic [31:0] scale_val;
      logic        last_row;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef struct packed {
      logic               special;
      logic [31:0]        special_val;
      logic               sign;
      logic signed [10:0] exp_sum;
      logic [47:0]        prod;
   } mul_s1_type;

   typedef struct packed {
      logic               special;
      logic [31:0]        special_val;
      logic               sign;
      logic signed [10:0] be;
      logic [47:0]        pn;
   } mul_s2_type;

   typedef struct packed {
      logic        special;
      logic [31:0] special_val;
      logic        sign;
      logic        zero_sign;
      logic [8:0]  e;
      logic [27:0] sum;
   } add_s1_type;

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      n = 6'd47;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) n = 6'(47 - i);
      end
      return n;
   endfunction

   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] n;
      n = 5'd26;
      for (int i = 0; i < 27; i++) begin
         if (v[i]) n = 5'(26 - i);
      end
      return n;
   endfunction

   // Sign-extended int8 to single precision; always exact.
   function automatic logic [31:0] int8_to_float(input logic [7:0] b);
      logic [7:0]  mag;
      logic [2:0]  p;
      logic [23:0] m;
      mag = b[7] ? 8'(-b) : b;
      p = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (mag[i]) p = 3'(i);
      end
      m = {mag, 16'd0} << (3'd7 - p);
      if (mag == 8'd0) return 32'd0;
      return {b[7], 8'(8'd127 + {5'd0, p}), m[22:0]};
   endfunction

   // Multiply, first step: special operands and the raw significand product.
   function automatic mul_s1_type mul_stage1(input logic [31:0] a, input logic [31:0] b);
      mul_s1_type r;
      logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      logic [7:0] ea, eb;
      logic [23:0] ma, mb;
      a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      r.sign    = a[31] ^ b[31];
      r.exp_sum = $signed({3'd0, ea}) + $signed({3'd0, eb});
      r.prod    = 48'(ma) * 48'(mb);
      r.special = 1'b1;
      priority if (a_nan) r.special_val = a | QuietBit;
      else if (b_nan) r.special_val = b | QuietBit;
      else if ((a_inf && b_zero) || (b_inf && a_zero)) r.special_val = DefaultNan;
      else if (a_inf || b_inf) r.special_val = {r.sign, 8'hFF, 23'd0};
      else if (a_zero || b_zero) r.special_val = {r.sign, 31'd0};
      else begin
         r.special     = 1'b0;
         r.special_val = 32'd0;
      end
      return r;
   endfunction

   // Multiply, second step: bring the leading one of the product to the top.
   function automatic mul_s2_type mul_stage2(input mul_s1_type s);
      mul_s2_type r;
      logic [5:0] lz;
      lz = lzc48(s.prod);
      r.special     = s.special;
      r.special_val = s.special_val;
      r.sign        = s.sign;
      r.pn          = s.prod << lz;
      r.be          = s.exp_sum - 11'sd126 - $signed({5'd0, lz});
      return r;
   endfunction

   // Multiply, last step: subnormal shift, round to nearest even, pack.
   function automatic logic [31:0] mul_stage3(input mul_s2_type s);
      logic signed [10:0] sh;
      logic [47:0] shifted, mask;
      logic [30:0] packed_v;
      logic g, st;
      sh = 11'sd1 - s.be;
      if (s.special) return s.special_val;
      if (s.be >= 11'sd255) return {s.sign, 8'hFF, 23'd0};
      if (s.be >= 11'sd1) begin
         packed_v = {s.be[7:0], s.pn[46:24]};
         g  = s.pn[23];
         st = |s.pn[22:0];
      end else if (sh >= 11'sd48) begin
         packed_v = 31'd0;
         g  = 1'b0;
         st = 1'b1;
      end else begin
         shifted  = s.pn >> sh[5:0];
         mask     = ~({48{1'b1}} << sh[5:0]);
         packed_v = {8'd0, shifted[46:24]};
         g  = shifted[23];
         st = (|shifted[22:0]) | (|(s.pn & mask));
      end
      return {s.sign, packed_v + {30'd0, g & (st | packed_v[0])}};
   endfunction

   // Add, first step: special operands, alignment and the raw sum.
   function automatic add_s1_type add_stage1(input logic [31:0] a, input logic [31:0] b);
      add_s1_type r;
      logic a_nan, b_nan, a_inf, b_inf, swap;
      logic [31:0] big, sml;
      logic [7:0] e_big, e_sml, d;
      logic [26:0] big27, s27, al;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      swap  = b[30:0] > a[30:0];
      big   = swap ? b : a;
      sml   = swap ? a : b;
      e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      d     = e_big - e_sml;
      big27 = {big[30:23] != 8'd0, big[22:0], 3'd0};
      s27   = {sml[30:23] != 8'd0, sml[22:0], 3'd0};
      if (d >= 8'd27) begin
         al = {26'd0, |s27};
      end else begin
         al = (s27 >> d[4:0]) | {26'd0, |(s27 & ~({27{1'b1}} << d[4:0]))};
      end
      r.sign      = big[31];
      r.zero_sign = a[31] & b[31];
      r.e         = {1'b0, e_big};
      r.sum       = (big[31] != sml[31]) ? ({1'b0, big27} - {1'b0, al})
                                         : ({1'b0, big27} + {1'b0, al});
      r.special   = 1'b1;
      priority if (a_nan) r.special_val = a | QuietBit;
      else if (b_nan) r.special_val = b | QuietBit;
      else if (a_inf && b_inf && (a[31] != b[31])) r.special_val = DefaultNan;
      else if (a_inf) r.special_val = a;
      else if (b_inf) r.special_val = b;
      else begin
         r.special     = 1'b0;
         r.special_val = 32'd0;
      end
      return r;
   endfunction

   // Add, last step: normalize, round to nearest even, pack.
   function automatic logic [31:0] add_stage2(input add_s1_type s);
      logic [26:0] m;
      logic [9:0]  e_n, lim;
      logic [4:0]  lz, sh;
      logic [7:0]  ef;
      logic [30:0] packed_v;
      if (s.special) return s.special_val;
      if (s.sum == 28'd0) return {s.zero_sign, 31'd0};
      if (s.sum[27]) begin
         m   = {s.sum[27:2], s.sum[1] | s.sum[0]};
         e_n = {1'b0, s.e} + 10'd1;
      end else begin
         lz  = lzc27(s.sum[26:0]);
         lim = {1'b0, s.e} - 10'd1;
         sh  = ({5'd0, lz} < lim) ? lz : lim[4:0];
         m   = s.sum[26:0] << sh;
         e_n = {1'b0, s.e} - {5'd0, sh};
      end
      if (e_n >= 10'd255) return {s.sign, 8'hFF, 23'd0};
      ef       = m[26] ? e_n[7:0] : 8'd0;
      packed_v = {ef, m[25:3]};
      return {s.sign, packed_v + {30'd0, m[2] & (m[1] | m[0] | m[3])}};
   endfunction

endpackage

>>> hdl/compressed_weight_matvec_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compressed_weight_matvec_unit
// Matrix-vector product of fp32 activations with bf16 or int8 weights.
// ----------------------------------------------------------------------------
// Usage: write the four configuration registers through the csr_ port while
// the block is idle. Then send activation items (req_kind 0) to fill the
// activation store, followed by weight items (req_kind 1) row by row in
// element order; req_row_value is taken on each row's first weight.
// One result item leaves on the rsp_ channel per finished row, with
// rsp_last_row set on the final row of the product.
// Flow: after an activation item the front can take the next item; after a
// weight item it drops req_ready while it reads the activation store. In the
// back end the single-precision multiply (three stages) and in-order add (two
// stages) form the loop on the row sum, so it starts a new weight only once
// the previous one has left the add. After a row's last add its result goes
// to the output register, for int8 rows after a multiply by the row scale.
// A four-entry queue between front and back lets the front run ahead.
// Reset clears all control state; the activation store holds undefined data
// until written. When the receiver stalls, the result stays in the output
// register, the back end waits and the queue fills, then req_ready drops.
// ----------------------------------------------------------------------------
module compressed_weight_matvec_unit
   import cwmv_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_kind,
   input  logic [AddrWidth-1:0]     req_element_index,
   input  logic [31:0]              req_activation_bits,
   input  logic [15:0]              req_weight_bits,
   input  logic [31:0]              req_row_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [31:0]              rsp_row_result,
   output logic                     rsp_last_row,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_write_data
);

   fifo_status_type fifo_status;
   entry_type       push_entry, head;
   logic            push, pop;

   // Front end: handshake, counters and classification of each item.
   cwmv_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_element_index   (req_element_index),
      .req_activation_bits (req_activation_bits),
      .req_weight_bits     (req_weight_bits),
      .req_row_value       (req_row_value),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .fifo_status         (fifo_status),
      .push                (push),
      .push_entry          (push_entry)
   );

   // The queue decouples the two halves.
   cwmv_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (fifo_status)
   );

   // Back end: floating-point arithmetic and the result register.
   cwmv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .fifo_status    (fifo_status),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_row_result (rsp_row_result),
      .rsp_last_row   (rsp_last_row)
   );

endmodule

>>> hdl/cwmv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwmv_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module cwmv_ram #(
   parameter int Width = 32,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(Depth)-1:0] address,
   input  logic [Width-1:0]         write_data,
   output logic [Width-1:0]         read_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[address] <= write_data;
      end
      read_data_ff <= mem[address];
   end

   assign read_data = read_data_ff;

endmodule

>>> hdl/cwmv_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwmv_fifo
// Short queue of classified weight items between front and back end.
// ----------------------------------------------------------------------------
module cwmv_fifo
   import cwmv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  entry_type       push_entry,
   input  logic            pop,
   output entry_type       head,
   output fifo_status_type status
);

   entry_type                slot_ff [FifoDepth];
   logic [FifoPtrWidth-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [FifoPtrWidth:0]    count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (FifoPtrWidth+1)'(push) - (FifoPtrWidth+1)'(pop);
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (FifoPtrWidth+1)'(FifoDepth));
   assign status.empty = (count_ff == '0);

endmodule

>>> hdl/cwmv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwmv_front
// Accepts items, keeps configuration and row/element counters, writes the
// activation store and turns each weight into a classified queue entry.
// ----------------------------------------------------------------------------
module cwmv_front
   import cwmv_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_kind,
   input  logic [AddrWidth-1:0]     req_element_index,
   input  logic [31:0]              req_activation_bits,
   input  logic [15:0]              req_weight_bits,
   input  logic [31:0]              req_row_value,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_write_data,
   input  fifo_status_type          fifo_status,
   output logic                     push,
   output entry_type                push_entry
);

   logic                 wf_ff, bias_ff;
   logic [LenWidth-1:0]  rlen_ff, ec_ff, ec_in, len, ec_c, ec_next;
   logic [RowsWidth-1:0] rows_ff, rc_ff, rc_in, rows;
   logic [31:0]          held_ff, held_in;
   logic                 pend_ff;
   entry_type            pend_entry_ff, pend_entry_in;
   logic                 accept, accept_weight, last, last_row;
   logic [RowsWidth:0]   rc_next;
   logic [31:0]          ram_rdata;

   assign req_ready     = !pend_ff && !fifo_status.full;
   assign accept        = req_valid && req_ready;
   assign accept_weight = accept && (req_kind == KIND_WEIGHT);

   always_comb begin
      if (rlen_ff == '0) len = LenWidth'(1);
      else if (rlen_ff > LenWidth'(MaxRowLength)) len = LenWidth'(MaxRowLength);
      else len = rlen_ff;
      rows     = (rows_ff == '0) ? RowsWidth'(1) : rows_ff;
      ec_c     = (ec_ff >= len) ? len - 1'b1 : ec_ff;
      ec_next  = ec_c + 1'b1;
      last     = (ec_next >= len);
      rc_next  = {1'b0, rc_ff} + 1'b1;
      last_row = (rc_next >= {1'b0, rows});
      held_in  = (ec_c == '0) ? req_row_value : held_ff;
      ec_in    = last ? '0 : ec_next;
      rc_in    = last_row ? '0 : rc_next[RowsWidth-1:0];

      pend_entry_in.weight    = (wf_ff == FMT_INT8) ? int8_to_float(req_weight_bits[7:0])
                                                    : {req_weight_bits, 16'd0};
      pend_entry_in.act       = 32'd0;
      pend_entry_in.first     = (ec_c == '0);
      pend_entry_in.start     = ((wf_ff == FMT_BF16) && bias_ff) ? req_row_value : 32'd0;
      pend_entry_in.last      = last;
      pend_entry_in.scale     = (wf_ff == FMT_INT8);
      pend_entry_in.scale_val = held_in;
      pend_entry_in.last_row  = last_row;
   end

   always_ff @(posedge clock) begin
      if (accept_weight) begin
         pend_entry_ff <= pend_entry_in;
         held_ff       <= held_in;
      end
      if (reset) begin
         wf_ff   <= FMT_BF16;
         bias_ff <= 1'b0;
         rlen_ff <= LenWidth'(1);
         rows_ff <= RowsWidth'(1);
         ec_ff   <= '0;
         rc_ff   <= '0;
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= accept_weight;
         if (accept_weight) begin
            ec_ff <= ec_in;
            if (last) rc_ff <= rc_in;
         end
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_WEIGHT_FORMAT: wf_ff   <= csr_write_data[0];
               CSR_BIAS_ENABLE:   bias_ff <= csr_write_data[0];
               CSR_ROW_LENGTH:    rlen_ff <= csr_write_data[LenWidth-1:0];
               CSR_ROWS_IN_USE:   rows_ff <= csr_write_data[RowsWidth-1:0];
               default:           ;
            endcase
         end
      end
   end

   cwmv_ram #(
      .Width (32),
      .Depth (MaxRowLength)
   ) u_act_ram (
      .clock        (clock),
      .write_enable (accept && (req_kind == KIND_ACTIVATION)),
      .address      ((req_kind == KIND_ACTIVATION) ? req_element_index : ec_c[AddrWidth-1:0]),
      .write_data   (req_activation_bits),
      .read_data    (ram_rdata)
   );

   always_comb begin
      push_entry     = pend_entry_ff;
      push_entry.act = ram_rdata;
   end
   assign push = pend_ff;

endmodule

>>> hdl/cwmv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwmv_back
// Arithmetic back end: rounded product, in-order row sum, optional row
// scale, and the output register of the result channel.
// ----------------------------------------------------------------------------
module cwmv_back
   import cwmv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  fifo_status_type fifo_status,
   input  entry_type       head,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [31:0]     rsp_row_result,
   output logic            rsp_last_row
);

   back_state_type state_ff, state_in;
   entry_type      cur_ff;
   logic [31:0]    mul_a_ff, mul_b_ff, prod_ff, sum_ff, result_ff;
   mul_s1_type     s1_ff, s1_c;
   mul_s2_type     s2_ff, s2_c;
   add_s1_type     as1_ff, as1_c;
   logic [31:0]    m3_c, sum_c;
   logic           scale_phase_ff;
   logic           rsp_valid_ff, rsp_last_ff;
   logic [31:0]    rsp_result_ff;
   logic           out_free;
   logic           ld_head, ld_scale, prod_en, result_en, sum_en, out_load;

   assign s1_c     = mul_stage1(mul_a_ff, mul_b_ff);
   assign s2_c     = mul_stage2(s1_ff);
   assign m3_c     = mul_stage3(s2_ff);
   assign as1_c    = add_stage1(cur_ff.first ? cur_ff.start : sum_ff, prod_ff);
   assign sum_c    = add_stage2(as1_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (!fifo_status.empty) state_in = B_MUL1;
         B_MUL1: state_in = B_MUL2;
         B_MUL2: state_in = B_MUL3;
         B_MUL3: state_in = scale_phase_ff ? B_FIN : B_ADD1;
         B_ADD1: state_in = B_ADD2;
         B_ADD2: begin
            if (cur_ff.last) state_in = cur_ff.scale ? B_MUL1 : B_FIN;
            else state_in = fifo_status.empty ? B_IDLE : B_MUL1;
         end
         B_FIN: if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      ld_head   = 1'b0;
      ld_scale  = 1'b0;
      prod_en   = 1'b0;
      result_en = 1'b0;
      sum_en    = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         B_IDLE: ld_head = !fifo_status.empty;
         B_MUL3: begin
            prod_en   = !scale_phase_ff;
            result_en = scale_phase_ff;
         end
         B_ADD2: begin
            sum_en    = 1'b1;
            ld_head   = !cur_ff.last && !fifo_status.empty;
            ld_scale  = cur_ff.last && cur_ff.scale;
            result_en = cur_ff.last && !cur_ff.scale;
         end
         B_FIN: out_load = out_free;
         default: ;
      endcase
   end

   assign pop = ld_head;

   always_ff @(posedge clock) begin
      s1_ff  <= s1_c;
      s2_ff  <= s2_c;
      as1_ff <= as1_c;
      if (ld_head) begin
         cur_ff   <= head;
         mul_a_ff <= head.weight;
         mul_b_ff <= head.act;
      end
      if (ld_scale) begin
         mul_a_ff <= sum_c;
         mul_b_ff <= cur_ff.scale_val;
      end
      if (prod_en) prod_ff <= m3_c;
      if (sum_en) sum_ff <= sum_c;
      if (result_en) result_ff <= scale_phase_ff ? m3_c : sum_c;
      if (out_load) begin
         rsp_result_ff <= result_ff;
         rsp_last_ff   <= cur_ff.last_row;
      end
      if (reset) begin
         state_ff       <= B_IDLE;
         scale_phase_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ld_head) scale_phase_ff <= 1'b0;
         else if (ld_scale) scale_phase_ff <= 1'b1;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_result = rsp_result_ff;
   assign rsp_last_row   = rsp_last_ff;

endmodule

>>> hdl/cwmv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwmv_checker
// Port-level checks of the matrix-vector unit, bound to the top level.
// ----------------------------------------------------------------------------
module cwmv_checker
   import cwmv_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     req_kind,
   input logic [AddrWidth-1:0]     req_element_index,
   input logic [31:0]              req_activation_bits,
   input logic [15:0]              req_weight_bits,
   input logic [31:0]              req_row_value,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [31:0]              rsp_row_result,
   input logic                     rsp_last_row,
   input logic                     csr_write_enable,
   input logic [CsrIndexWidth-1:0] csr_index,
   input logic [CsrDataWidth-1:0]  csr_write_data
);

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_result)
                                  && $stable(rsp_last_row))
      else $error("stalled result changed");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An accepted weight occupies the store read port, so req_ready drops while it is read.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_WEIGHT) |=> !req_ready)
      else $error("item taken during activation read");

endmodule

bind compressed_weight_matvec_unit cwmv_checker u_checker (.*);
